### src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define CHK_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, off during reset
`define CHK_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

// next-cycle implication that also holds across reset
`define CHK_NEXT_ALWAYS(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) (pre) |=> (post)) else $error(msg);

`endif

### src/ipv4dq_pkg.sv
`default_nettype none

package ipv4dq_pkg;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       is_last;
    logic       no_char;
  } item_t;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_EMPTY   = 3'd1;
  localparam logic [2:0] ST_BADCHAR = 3'd2;
  localparam logic [2:0] ST_RANGE   = 3'd3;
  localparam logic [2:0] ST_FORMAT  = 3'd4;

  localparam logic [7:0] CHAR_DOT    = 8'h2E;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = CHAR_ZERO + 8'd9;
  localparam logic [7:0] OCTET_MAX   = 8'd255;
  localparam logic [3:0] RADIX       = 4'd10;
  localparam logic [1:0] DOTS_NEEDED = 2'd3;

endpackage

`default_nettype wire

### src/ipv4dq_in_reg.sv
`default_nettype none

module ipv4dq_in_reg (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  ipv4dq_pkg::item_t    in_item,
  input  wire                  take,
  output logic                 s1_valid,
  output ipv4dq_pkg::item_t    s1_item
);
  import ipv4dq_pkg::*;

  logic  s1_valid_r;
  logic  s1_valid_nxt;
  item_t s1_item_r;

  assign in_ready = !s1_valid_r || take;
  assign s1_valid = s1_valid_r;
  assign s1_item  = s1_item_r;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_ready) begin
      s1_valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_item;
    end
  end

endmodule

`default_nettype wire

### src/ipv4dq_parser.sv
`default_nettype none

module ipv4dq_parser (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  take,
  input  ipv4dq_pkg::item_t    item,
  output logic                 res_valid,
  output logic [2:0]           res_status
);
  import ipv4dq_pkg::*;

  logic [1:0]  dots_r, dots_nxt;
  logic [7:0]  octet_r, octet_nxt;
  logic [2:0]  err_r, err_nxt;
  logic        seen_r, seen_nxt;

  logic        is_digit;
  logic [11:0] acc;

  assign is_digit = (item.char_byte >= CHAR_ZERO) && (item.char_byte <= CHAR_NINE);
  // octet * 10 + digit, at most 2559
  assign acc = ({4'b0, octet_r} * {8'b0, RADIX}) + {8'b0, item.char_byte[3:0]};

  always_comb begin
    dots_nxt   = dots_r;
    octet_nxt  = octet_r;
    err_nxt    = err_r;
    seen_nxt   = seen_r;
    res_status = ST_OK;

    if (!item.no_char) begin
      seen_nxt = 1'b1;
      if (err_r == ST_OK) begin
        if (is_digit) begin
          if (acc > {4'b0, OCTET_MAX}) begin
            err_nxt = ST_RANGE;
          end else begin
            octet_nxt = acc[7:0];
          end
        end else if (item.char_byte == CHAR_DOT && dots_r != DOTS_NEEDED) begin
          dots_nxt  = dots_r + 2'd1;
          octet_nxt = 8'd0;
        end else begin
          err_nxt = ST_BADCHAR;
        end
      end
    end

    if (!seen_nxt) begin
      res_status = ST_EMPTY;
    end else if (err_nxt != ST_OK) begin
      res_status = err_nxt;
    end else if (dots_nxt != DOTS_NEEDED) begin
      res_status = ST_FORMAT;
    end

    // string done: start clean
    if (item.is_last) begin
      dots_nxt  = 2'd0;
      octet_nxt = 8'd0;
      err_nxt   = ST_OK;
      seen_nxt  = 1'b0;
    end
  end

  assign res_valid = take && item.is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dots_r  <= 2'd0;
      octet_r <= 8'd0;
      err_r   <= ST_OK;
      seen_r  <= 1'b0;
    end else if (take) begin
      dots_r  <= dots_nxt;
      octet_r <= octet_nxt;
      err_r   <= err_nxt;
      seen_r  <= seen_nxt;
    end
  end

endmodule

`default_nettype wire

### src/ipv4dq_out_reg.sv
`default_nettype none

module ipv4dq_out_reg (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        load,
  input  wire  [2:0] status_in,
  output logic       free,
  output logic       out_valid,
  input  wire        out_ready,
  output logic [2:0] out_status
);

  logic       out_valid_r, out_valid_nxt;
  logic [2:0] out_status_r;

  assign free       = !out_valid_r || out_ready;
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_status_r <= status_in;
    end
  end

endmodule

`default_nettype wire

### src/ipv4_dotted_quad_checker_core.sv
// Checks a text string, one character word per cycle, against the IPv4
// dotted-decimal form and gives one status word when the word marked last
// has gone through (0 ok, 1 empty, 2 invalid character, 3 octet out of
// range, 4 bad format; the first error of a string wins). One word is taken
// every cycle unless a last word waits for room in the output register;
// each word passes one input register and a state update (multiply-by-ten,
// add and compare on the current octet), and a string's status then passes
// one output register. Non-last words never wait on the output side.
`default_nettype none

module ipv4_dotted_quad_checker_core (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_ready,
  input  wire  [7:0] in_char_byte,
  input  wire        in_is_last,
  input  wire        in_no_char,
  output logic       out_valid,
  input  wire        out_ready,
  output logic [2:0] out_status
);
  import ipv4dq_pkg::*;

  item_t      in_item;
  item_t      s1_item;
  logic       s1_valid;
  logic       take;
  logic       out_free;
  logic       res_valid;
  logic [2:0] res_status;

  assign in_item.char_byte = in_char_byte;
  assign in_item.is_last   = in_is_last;
  assign in_item.no_char   = in_no_char;

  // a last word needs room in the output register
  assign take = s1_valid && (!s1_item.is_last || out_free);

  ipv4dq_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .take     (take),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  ipv4dq_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .item       (s1_item),
    .res_valid  (res_valid),
    .res_status (res_status)
  );

  ipv4dq_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (res_valid),
    .status_in  (res_status),
    .free       (out_free),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_status (out_status)
  );

endmodule

`default_nettype wire

### src/ipv4dq_checker.sv
`default_nettype none
`include "assert_macros.svh"

module ipv4dq_checker (
  input wire       clk,
  input wire       rst_n,
  input wire       out_valid,
  input wire       out_ready,
  input wire [2:0] out_status
);
  import ipv4dq_pkg::*;

  `CHK_NEXT_ALWAYS(a_rst_idle, !rst_n, !out_valid, "result word shown right after reset")
  `CHK_NOW(a_status_code, out_valid, out_status <= ST_FORMAT, "status code out of range")
  `CHK_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "stalled result dropped")
  `CHK_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_status), "stalled status changed")

endmodule

bind ipv4_dotted_quad_checker_core ipv4dq_checker u_ipv4dq_checker (.*);

`default_nettype wire
